[rtl/yta_pkg.sv]
// Shared types and fixed-point coefficients for the YUV to ARGB converter.
package yta_pkg;

	// Coefficients, Q16, stored as signed so that they multiply signed chroma
	localparam logic signed [17:0] K_CR_RED   = 18'sd113443;
	localparam logic signed [17:0] K_CR_GREEN = 18'sd45744;
	localparam logic signed [17:0] K_CB_GREEN = 18'sd22020;
	localparam logic signed [17:0] K_CB_BLUE  = 18'sd113508;

	// Rounding offset of one half in Q16
	localparam logic signed [25:0] ROUND_HALF = 26'sd32768;

	// Constant alpha byte
	localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

	// One converted pixel, each channel already saturated
	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

endpackage

[rtl/yta_matrix.sv]
// Color matrix: chroma terms, channel sums and saturation for one pixel.
module yta_matrix (
	input  logic [7:0]     luma,
	input  logic [7:0]     chroma_blue,
	input  logic [7:0]     chroma_red,
	output yta_pkg::rgb_t  rgb
);
	import yta_pkg::*;

	logic signed [7:0]  cb_off;
	logic signed [7:0]  cr_off;
	logic signed [9:0]  term_rv;
	logic signed [9:0]  term_gv;
	logic signed [9:0]  term_gu;
	logic signed [9:0]  term_bu;
	logic signed [10:0] y_ext;
	logic signed [10:0] sum_r;
	logic signed [10:0] sum_g;
	logic signed [10:0] sum_b;

	// floor((k * c + 32768) / 65536) with c already offset by -128
	function automatic logic signed [9:0] chroma_term(
		input logic signed [17:0] k,
		input logic signed [7:0]  c
	);
		logic signed [25:0] prod;
		logic signed [25:0] acc;
		begin
			prod = 26'(k * c);
			acc  = prod + ROUND_HALF;
			chroma_term = acc[25:16];
		end
	endfunction

	// Clamp a channel sum to one byte
	function automatic logic [7:0] sat_byte(input logic signed [10:0] v);
		begin
			if (v < 11'sd0) begin
				sat_byte = 8'd0;
			end else if (v > 11'sd255) begin
				sat_byte = 8'd255;
			end else begin
				sat_byte = v[7:0];
			end
		end
	endfunction

	// Remove the 128 offset: flip the top bit to get a two's complement byte
	assign cb_off = $signed({~chroma_blue[7], chroma_blue[6:0]});
	assign cr_off = $signed({~chroma_red[7], chroma_red[6:0]});

	assign term_rv = chroma_term(K_CR_RED, cr_off);
	assign term_gv = chroma_term(K_CR_GREEN, cr_off);
	assign term_gu = chroma_term(K_CB_GREEN, cb_off);
	assign term_bu = chroma_term(K_CB_BLUE, cb_off);

	// Add the terms to luma
	assign y_ext = $signed({3'b000, luma});
	assign sum_r = y_ext + 11'(term_rv);
	assign sum_g = y_ext - 11'(term_gv) - 11'(term_gu);
	assign sum_b = y_ext + 11'(term_bu);

	assign rgb.red   = sat_byte(sum_r);
	assign rgb.green = sat_byte(sum_g);
	assign rgb.blue  = sat_byte(sum_b);

endmodule

[rtl/yuv_to_argb_pixel_converter_core.sv]
// Top level of the YUV to ARGB pixel converter.
// Converts one pixel per clock. A word is taken at every rising edge where
// start is high; busy is tied low, so start may stay high in every cycle.
// The input word is held in one input register, converted, and packed into
// one result register; the ARGB word then appears on argb_word, marked by
// done for exactly one cycle. The receiver cannot stall, so each result must be
// captured in the cycle done is high. Alpha is always 0xFF; red, green and
// blue saturate to 0..255.
module yuv_to_argb_pixel_converter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [7:0]  luma,
	input  logic [7:0]  chroma_blue,
	input  logic [7:0]  chroma_red,
	output logic        done,
	output logic [31:0] argb_word
);
	import yta_pkg::*;

	logic        valid_s1;
	logic [7:0]  luma_s1;
	logic [7:0]  cb_s1;
	logic [7:0]  cr_s1;
	rgb_t        rgb;
	logic        valid_s2;
	logic [31:0] word_s2;

	// Never hold off the source
	assign busy = 1'b0;

	// Track valid words through both stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
		end
	end

	// Capture the input word
	always_ff @(posedge clk) begin
		if (start) begin
			luma_s1 <= luma;
			cb_s1   <= chroma_blue;
			cr_s1   <= chroma_red;
		end
	end

	yta_matrix u_matrix (
		.luma        (luma_s1),
		.chroma_blue (cb_s1),
		.chroma_red  (cr_s1),
		.rgb         (rgb)
	);

	// Pack the result word
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			word_s2 <= {ALPHA_OPAQUE, rgb.red, rgb.green, rgb.blue};
		end
	end

	assign done      = valid_s2;
	assign argb_word = word_s2;

	// Every accepted word comes out through the input and result registers
	a_start_done: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##2 done)
		else $error("accepted word did not produce a result");

	// No result appears without an accepted word
	a_no_extra: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##2 !done)
		else $error("result produced without an accepted word");

	// Delivered words are always opaque
	a_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (argb_word[31:24] == ALPHA_OPAQUE))
		else $error("alpha byte not opaque");

endmodule

[verif/tb_top.sv]
// Self-checking testbench for the YUV to ARGB pixel converter core.
`timescale 1ns / 100ps

module tb_top;
	import yta_pkg::*;

	localparam int CLK_HALF        = 4;
	localparam int RESET_CYCLES    = 2;
	localparam int RANDOM_WORDS    = 650;
	localparam int IDLE_PERCENT    = 21;
	localparam int QUIET_FIRST     = 200;
	localparam int QUIET_LAST      = 349;
	localparam int DRAIN_CYCLES    = 8;
	localparam int WATCHDOG_CYCLES = 200000;
	localparam int MAX_REPORTS     = 10;

	// Q16 color coefficients
	localparam int COEF_CR_RED   = 113443;
	localparam int COEF_CR_GREEN = 45744;
	localparam int COEF_CB_GREEN = 22020;
	localparam int COEF_CB_BLUE  = 113508;
	localparam int Q16_HALF      = 32768;
	localparam int CHROMA_ZERO   = 128;

	typedef struct packed {
		logic [7:0]  y;
		logic [7:0]  cb;
		logic [7:0]  cr;
		logic        known;
		logic [31:0] word;
	} pixel_row_t;

	localparam int TABLE_ROWS = 23;

	// Directed pixels; rows with known set carry a hand-worked word
	localparam pixel_row_t PIXEL_TABLE [TABLE_ROWS] = '{
		'{8'd0,   8'd128, 8'd128, 1'b1, 32'hFF000000},	// black, neutral chroma
		'{8'd255, 8'd128, 8'd128, 1'b1, 32'hFFFFFFFF},	// white, neutral chroma
		'{8'd128, 8'd128, 8'd128, 1'b1, 32'hFF808080},	// mid gray
		'{8'd0,   8'd0,   8'd0,   1'b1, 32'hFF008400},	// red and blue clamp low
		'{8'd255, 8'd255, 8'd255, 1'b1, 32'hFFFF7BFF},	// red and blue clamp high
		'{8'd0,   8'd255, 8'd255, 1'b0, 32'h0},
		'{8'd255, 8'd0,   8'd0,   1'b0, 32'h0},
		'{8'd0,   8'd0,   8'd255, 1'b0, 32'h0},
		'{8'd0,   8'd255, 8'd0,   1'b0, 32'h0},
		'{8'd255, 8'd0,   8'd255, 1'b0, 32'h0},
		'{8'd255, 8'd255, 8'd0,   1'b0, 32'h0},
		'{8'd16,  8'd128, 8'd128, 1'b0, 32'h0},
		'{8'd235, 8'd128, 8'd128, 1'b0, 32'h0},
		'{8'd16,  8'd16,  8'd16,  1'b0, 32'h0},
		'{8'd235, 8'd240, 8'd240, 1'b0, 32'h0},
		'{8'd128, 8'd129, 8'd127, 1'b0, 32'h0},	// rounding just off neutral
		'{8'd128, 8'd127, 8'd129, 1'b0, 32'h0},
		'{8'd1,   8'd128, 8'd129, 1'b0, 32'h0},
		'{8'd254, 8'd127, 8'd128, 1'b0, 32'h0},
		'{8'd81,  8'd90,  8'd240, 1'b0, 32'h0},	// saturated red
		'{8'd145, 8'd54,  8'd34,  1'b0, 32'h0},	// saturated green
		'{8'd41,  8'd240, 8'd110, 1'b0, 32'h0},	// saturated blue
		'{8'd170, 8'd166, 8'd16,  1'b0, 32'h0}
	};

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic [7:0]  luma;
	logic [7:0]  chroma_blue;
	logic [7:0]  chroma_red;
	logic        done;
	logic [31:0] argb_word;

	logic [31:0] pending_argb [$];
	int          pixels_sent;
	int          words_checked;
	int          mismatches;
	int          stray_words;
	int          cycle_count;
	bit          idle_on;

	yuv_to_argb_pixel_converter_core uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.luma        (luma),
		.chroma_blue (chroma_blue),
		.chroma_red  (chroma_red),
		.done        (done),
		.argb_word   (argb_word)
	);

	initial begin
		clk = 1'b0;
	end

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// floor((coeff * (c - 128) + 0.5) in Q16), arithmetic shift
	function automatic int chroma_offset(input int coeff, input logic [7:0] c);
		int prod;
		prod = coeff * (int'(c) - CHROMA_ZERO) + Q16_HALF;
		return prod >>> 16;
	endfunction

	function automatic logic [7:0] clamp_byte(input int v);
		if (v < 0)
			return 8'd0;
		if (v > 255)
			return 8'd255;
		return v[7:0];
	endfunction

	// Expected packed ARGB word for one pixel
	function automatic logic [31:0] argb_of(input logic [7:0] y, input logic [7:0] cb,
			input logic [7:0] cr);
		rgb_t px;
		int   base;
		base     = int'(y);
		px.red   = clamp_byte(base + chroma_offset(COEF_CR_RED, cr));
		px.green = clamp_byte(base - chroma_offset(COEF_CR_GREEN, cr)
				- chroma_offset(COEF_CB_GREEN, cb));
		px.blue  = clamp_byte(base + chroma_offset(COEF_CB_BLUE, cb));
		return {ALPHA_OPAQUE, px};
	endfunction

	// Present one pixel, hold it until taken, then queue its expected word
	task automatic send_pixel(input logic [7:0] y, input logic [7:0] cb, input logic [7:0] cr,
			input logic known, input logic [31:0] word);
		while (idle_on && $urandom_range(99) < IDLE_PERCENT) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start       <= 1'b1;
		luma        <= y;
		chroma_blue <= cb;
		chroma_red  <= cr;
		do
			@(posedge clk);
		while (busy === 1'b1);
		pending_argb.push_back(known ? word : argb_of(y, cb, cr));
		pixels_sent++;
	endtask

	// Pick a byte biased toward the ends and the neutral point
	function automatic logic [7:0] edgy_byte();
		case ($urandom_range(3))
			0: return 8'($urandom_range(7));
			1: return 8'(255 - $urandom_range(7));
			2: return 8'(CHROMA_ZERO - 4 + $urandom_range(8));
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	// Compare each strobed word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done === 1'b1) begin
			if (pending_argb.size() == 0) begin
				stray_words++;
				$display("[%0t] unexpected word 0x%08h", $realtime, argb_word);
			end else begin
				logic [31:0] want;
				want = pending_argb.pop_front();
				words_checked++;
				if (argb_word !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("[%0t] word %0d: expected 0x%08h, got 0x%08h",
								$realtime, words_checked, want, argb_word);
				end
			end
		end
	end

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > WATCHDOG_CYCLES) begin
			$display("timeout after %0d cycles, %0d words outstanding",
					cycle_count, pending_argb.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		logic [7:0] y;
		logic [7:0] cb;
		logic [7:0] cr;
		arst_n        = 1'b0;
		start         = 1'b0;
		luma          = 8'd0;
		chroma_blue   = 8'd0;
		chroma_red    = 8'd0;
		pixels_sent   = 0;
		words_checked = 0;
		mismatches    = 0;
		stray_words   = 0;
		cycle_count   = 0;
		idle_on       = 1'b1;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		for (int i = 0; i < TABLE_ROWS; i++)
			send_pixel(PIXEL_TABLE[i].y, PIXEL_TABLE[i].cb, PIXEL_TABLE[i].cr,
					PIXEL_TABLE[i].known, PIXEL_TABLE[i].word);

		// Random pixels: mix uniform bytes with ones near the clamp points and the neutral point
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			idle_on = !(i >= QUIET_FIRST && i <= QUIET_LAST);
			if (i == RANDOM_WORDS / 2 + 100) begin
				// hold off until the pipeline has drained
				start <= 1'b0;
				@(posedge clk);
				while (pending_argb.size() != 0)
					@(posedge clk);
			end
			if ($urandom_range(9) < 6) begin
				y  = 8'($urandom_range(255));
				cb = 8'($urandom_range(255));
				cr = 8'($urandom_range(255));
			end else begin
				y  = edgy_byte();
				cb = edgy_byte();
				cr = edgy_byte();
			end
			send_pixel(y, cb, cr, 1'b0, 32'h0);
		end

		// Drain and watch for extra words
		start <= 1'b0;
		while (pending_argb.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("sent %0d pixels (%0d directed, %0d random), checked %0d words",
				pixels_sent, TABLE_ROWS, RANDOM_WORDS, words_checked);
		$display("mismatched words: %0d, unexpected words: %0d", mismatches, stray_words);
		if (mismatches == 0 && stray_words == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
